// File: sv/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// types, constants and cordic helpers for the 3-1-3 euler angle converter
// ----------------------------------------------------------------------------
package q2e_pkg;

	localparam int CW      = 34;
	localparam int AW      = 24;
	localparam int OW      = 16;
	localparam int TAB_LEN = 24;

	localparam logic signed [AW-1:0] PI_ACC = 24'sd3294199;
	localparam logic signed [OW-1:0] PI_OUT = 16'sd25736;

	typedef logic signed [CW-1:0] cvec_t;
	typedef logic signed [AW-1:0] acc_t;
	typedef logic signed [OW-1:0] ang_t;

	typedef struct packed {
		cvec_t x;
		cvec_t y;
		acc_t  acc;
		logic  zero;
	} cordic_t;

	function automatic acc_t atan_tab(input int i);
		acc_t t;
		unique case (i)
			0:       t = 24'sd823550;
			1:       t = 24'sd486170;
			2:       t = 24'sd256879;
			3:       t = 24'sd130396;
			4:       t = 24'sd65451;
			5:       t = 24'sd32757;
			6:       t = 24'sd16383;
			7:       t = 24'sd8192;
			8:       t = 24'sd4096;
			9:       t = 24'sd2048;
			10:      t = 24'sd1024;
			11:      t = 24'sd512;
			12:      t = 24'sd256;
			13:      t = 24'sd128;
			14:      t = 24'sd64;
			15:      t = 24'sd32;
			16:      t = 24'sd16;
			17:      t = 24'sd8;
			18:      t = 24'sd4;
			19:      t = 24'sd2;
			20:      t = 24'sd1;
			default: t = '0;
		endcase
		return t;
	endfunction

	// fold into the right half plane
	function automatic cordic_t cordic_prep(input cvec_t y, input cvec_t x);
		cordic_t c;
		c.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			c.x   = -x;
			c.y   = -y;
			c.acc = (y >= 0) ? PI_ACC : -PI_ACC;
		end else begin
			c.x   = x;
			c.y   = y;
			c.acc = '0;
		end
		return c;
	endfunction

	function automatic cordic_t cordic_step(input cordic_t c, input int i);
		cordic_t n;
		cvec_t   dx;
		cvec_t   dy;
		n  = c;
		dx = c.x >>> i;
		dy = c.y >>> i;
		if (!c.y[CW-1]) begin
			n.x   = c.x + dy;
			n.y   = c.y - dx;
			n.acc = c.acc + atan_tab(i);
		end else begin
			n.x   = c.x - dy;
			n.y   = c.y + dx;
			n.acc = c.acc - atan_tab(i);
		end
		return n;
	endfunction

	// round to 2^-13 rad and clamp to +-pi
	function automatic ang_t cordic_final(input cordic_t c);
		logic signed [AW:0]   t;
		logic signed [AW-7:0] r;
		ang_t                 a;
		t = {c.acc[AW-1], c.acc} + 25'sd64;
		r = signed'(t[AW:7]);
		if (c.zero) begin
			a = '0;
		end else if (r > 18'sd25736) begin
			a = PI_OUT;
		end else if (r < -18'sd25736) begin
			a = -PI_OUT;
		end else begin
			a = r[OW-1:0];
		end
		return a;
	endfunction

endpackage

// File: sv/quaternion_to_euler313.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler313
// converts a q1.14 quaternion into 3-1-3 euler angles at 2^-13 rad per lsb
// ----------------------------------------------------------------------------
// channel  | signals                                  | handshake
// input    | quat_w, quat_x, quat_y, quat_z           | start, busy
// result   | angle_psi, angle_theta, angle_phi        | done
//
// one beat enters per cycle; busy is always low
// the pipeline runs squares, clamp, product, one root bit per stage, the fold,
// then one cordic micro-rotation per stage, then final rounding and output
// reset clears only the valid bits
// done is high for a single cycle per beat; the receiver cannot stall
// ----------------------------------------------------------------------------
module quaternion_to_euler313 #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] quat_w,
	input  logic [15:0] quat_x,
	input  logic [15:0] quat_y,
	input  logic [15:0] quat_z,
	output logic        done,
	output logic [16:0] angle_psi,
	output logic [14:0] angle_theta,
	output logic [16:0] angle_phi
);
	import q2e_pkg::*;

	localparam int NI = (ANGLE_ITERATIONS < TAB_LEN) ? ANGLE_ITERATIONS : TAB_LEN;
	localparam int SQ = 29;

	// stage 1: squares
	logic                v_s1;
	logic [63:0]         q_s1;
	logic [30:0]         sw_s1, sx_s1, sy_s1, sz_s1;
	// stage 2: clamp
	logic                v_s2;
	logic [63:0]         q_s2;
	logic signed [29:0]  c_s2;
	logic [29:0]         a_s2, b_s2;
	// stage 3: product
	logic                v_s3;
	logic [63:0]         q_s3;
	logic signed [29:0]  c_s3;
	logic [56:0]         p_s3;
	// root stages
	logic                rt_v_s [0:SQ];
	logic [63:0]         rt_q_s [0:SQ];
	logic signed [29:0]  rt_c_s [0:SQ];
	logic [56:0]         rt_n_s [0:SQ];
	logic [57:0]         rt_r_s [0:SQ];
	// cordic stages
	logic                cv_s   [0:NI];
	cordic_t             ca_s   [0:NI];
	cordic_t             cb_s   [0:NI];
	cordic_t             cc_s   [0:NI];
	// final rounding
	logic                v_f;
	ang_t                a1_f, a2_f, a3_f;
	// output
	logic                done_q;
	logic signed [16:0]  psi_q, phi_q;
	logic [14:0]         theta_q;

	logic signed [32:0]  csum;
	logic signed [29:0]  cclamp;

	assign busy = 1'b0;

	always_comb begin
		csum = $signed({2'b00, sz_s1}) + $signed({2'b00, sw_s1})
			- $signed({2'b00, sx_s1}) - $signed({2'b00, sy_s1});
		if (csum > 33'sd268435456) begin
			cclamp = 30'sd268435456;
		end else if (csum < -33'sd268435456) begin
			cclamp = -30'sd268435456;
		end else begin
			cclamp = csum[29:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		q_s1  <= {quat_w, quat_x, quat_y, quat_z};
		sw_s1 <= 31'($signed({{16{quat_w[15]}}, quat_w}) * $signed({{16{quat_w[15]}}, quat_w}));
		sx_s1 <= 31'($signed({{16{quat_x[15]}}, quat_x}) * $signed({{16{quat_x[15]}}, quat_x}));
		sy_s1 <= 31'($signed({{16{quat_y[15]}}, quat_y}) * $signed({{16{quat_y[15]}}, quat_y}));
		sz_s1 <= 31'($signed({{16{quat_z[15]}}, quat_z}) * $signed({{16{quat_z[15]}}, quat_z}));
		q_s2  <= q_s1;
		c_s2  <= cclamp;
		a_s2  <= 30'(30'sd268435456 - cclamp);
		b_s2  <= 30'(30'sd268435456 + cclamp);
		q_s3  <= q_s2;
		c_s3  <= c_s2;
		p_s3  <= {27'd0, a_s2} * {27'd0, b_s2};
	end

	assign rt_v_s[0] = v_s3;
	assign rt_q_s[0] = q_s3;
	assign rt_c_s[0] = c_s3;
	assign rt_n_s[0] = p_s3;
	assign rt_r_s[0] = '0;

	// restoring square root, one result bit per stage
	for (genvar k = 0; k < SQ; k++) begin : g_root
		localparam logic [57:0] BIT = 58'(1) << (56 - 2 * k);
		logic [57:0] trial;
		assign trial = rt_r_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rt_q_s[k+1] <= rt_q_s[k];
			rt_c_s[k+1] <= rt_c_s[k];
			if ({1'b0, rt_n_s[k]} >= trial) begin
				rt_n_s[k+1] <= 57'({1'b0, rt_n_s[k]} - trial);
				rt_r_s[k+1] <= (rt_r_s[k] >> 1) + BIT;
			end else begin
				rt_n_s[k+1] <= rt_n_s[k];
				rt_r_s[k+1] <= rt_r_s[k] >> 1;
			end
		end
	end

	logic [15:0] qw, qx, qy, qz;
	cvec_t       vw, vx, vy, vz;
	assign {qw, qx, qy, qz} = rt_q_s[SQ];
	assign vw = cvec_t'({{(CW-30){qw[15]}}, qw, 14'b0});
	assign vx = cvec_t'({{(CW-30){qx[15]}}, qx, 14'b0});
	assign vy = cvec_t'({{(CW-30){qy[15]}}, qy, 14'b0});
	assign vz = cvec_t'({{(CW-30){qz[15]}}, qz, 14'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else begin
			cv_s[0] <= rt_v_s[SQ];
		end
	end

	always_ff @(posedge clk) begin
		ca_s[0] <= cordic_prep(vz, vw);
		cb_s[0] <= cordic_prep(vy, -vx);
		cc_s[0] <= cordic_prep(cvec_t'({1'b0, rt_r_s[SQ][28:0]}),
			cvec_t'(rt_c_s[SQ]));
	end

	for (genvar i = 0; i < NI; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			ca_s[i+1] <= cordic_step(ca_s[i], i);
			cb_s[i+1] <= cordic_step(cb_s[i], i);
			cc_s[i+1] <= cordic_step(cc_s[i], i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f    <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_f    <= cv_s[NI];
			done_q <= v_f;
		end
	end

	always_ff @(posedge clk) begin
		a1_f    <= cordic_final(ca_s[NI]);
		a2_f    <= cordic_final(cb_s[NI]);
		a3_f    <= cordic_final(cc_s[NI]);
		psi_q   <= 17'(a2_f) - 17'(a1_f);
		phi_q   <= -17'(a1_f) - 17'(a2_f);
		theta_q <= a3_f[OW-1] ? 15'd0 : a3_f[14:0];
	end

	assign done        = done_q;
	assign angle_psi   = psi_q;
	assign angle_theta = theta_q;
	assign angle_phi   = phi_q;

	a_theta_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> angle_theta <= 15'd25736)
		else $error("theta out of range");

	a_psi_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(angle_psi) <= 17'sd51472 && $signed(angle_psi) >= -17'sd51472))
		else $error("psi out of range");

	a_sum_even: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(angle_psi[0] ^ angle_phi[0]))
		else $error("psi and phi parity mismatch");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		v_f |=> done)
		else $error("result lost at output");

endmodule
